// ----- rtl/keyed_timing_stats_table_top_defines.svh -----
// Assertion macros used by the lookup stage (kts_front) of the keyed timing statistics table RTL.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef KEYED_TIMING_STATS_TABLE_TOP_DEFINES_SVH
`define KEYED_TIMING_STATS_TABLE_TOP_DEFINES_SVH

// Condition must hold at every edge out of reset.
`define KTS_CHECK(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("kts check failed");

// Antecedent implies consequent in the same cycle.
`define KTS_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kts implication failed");

// Antecedent implies consequent in the following cycle.
`define KTS_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kts next-cycle check failed");

`endif

// ----- rtl/kts_pkg.sv -----
// Types and constants for the keyed timing statistics table.
// No dependencies; used by every module in rtl except kts_ram.
package kts_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W       = 40;
  localparam int QDEPTH      = 2;

  typedef struct packed {
    logic [7:0]  type_id;
    logic [15:0] device_id;
    logic [15:0] metric_id;
    logic [47:0] wall_ns;
    logic [47:0] cpu_ns;
  } sample_t;

  typedef struct packed {
    logic        new_entry;
    logic        dropped;
    logic [63:0] drop_count;
    logic [31:0] call_count;
    logic [63:0] wall_total;
    logic [63:0] cpu_total;
    logic [63:0] wait_total;
    logic [47:0] wall_maximum;
    logic [47:0] wall_minimum;
  } result_t;

  // Classified request handed from lookup to update.
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             fresh;
    logic             drop;
    logic [63:0]      drop_count;
    logic [47:0]      wall;
    logic [47:0]      cpu;
  } cls_t;

  typedef struct packed {
    logic [31:0] calls;
    logic [63:0] wall_sum;
    logic [63:0] cpu_sum;
    logic [63:0] wait_sum;
    logic [47:0] wall_max;
    logic [47:0] wall_min;
  } stats_t;

  typedef enum logic [1:0] {F_IDLE, F_READ, F_CMP, F_PUSH} f_state_t;
  typedef enum logic [1:0] {B_IDLE, B_CALC, B_OUT} b_state_t;

endpackage

// ----- rtl/kts_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/kts_front.sv -----
// Lookup stage: scans the key RAM, allocates entries and counts drops.
// Depends on kts_pkg, kts_ram and the assertion macro header.
`include "keyed_timing_stats_table_top_defines.svh"

module kts_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  kts_pkg::sample_t sample,
  output logic            full,
  output logic            q_push,
  output kts_pkg::cls_t   q_item,
  input  logic            q_full
);

  kts_pkg::f_state_t state, state_next;
  kts_pkg::sample_t  smp;
  kts_pkg::cls_t     cls;
  logic [kts_pkg::CNT_W-1:0] scan_i;
  logic [kts_pkg::CNT_W-1:0] used;
  logic [63:0]               drop_counter;

  logic                      key_we;
  logic [kts_pkg::KEY_W-1:0] key_wdata;
  logic [kts_pkg::KEY_W-1:0] key_rdata;
  logic [kts_pkg::KEY_W-1:0] smp_key;
  logic                      at_end;
  logic                      tab_full;
  logic                      hit;
  logic                      drop_now;

  assign smp_key   = {smp.type_id, smp.device_id, smp.metric_id};
  assign key_wdata = smp_key;
  assign at_end    = (scan_i == used);
  assign tab_full  = (used == kts_pkg::CNT_W'(kts_pkg::TABLE_DEPTH));
  assign hit       = (key_rdata == smp_key);
  assign drop_now  = (state == kts_pkg::F_READ) && at_end && tab_full;

  kts_ram #(
    .WIDTH(kts_pkg::KEY_W),
    .DEPTH(kts_pkg::TABLE_DEPTH)
  ) u_key_ram (
    .clk  (clk),
    .we   (key_we),
    .waddr(used[kts_pkg::IDX_W-1:0]),
    .wdata(key_wdata),
    .raddr(scan_i[kts_pkg::IDX_W-1:0]),
    .rdata(key_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      kts_pkg::F_IDLE: begin
        if (push) state_next = kts_pkg::F_READ;
      end
      kts_pkg::F_READ: begin
        if (at_end) state_next = kts_pkg::F_PUSH;
        else        state_next = kts_pkg::F_CMP;
      end
      kts_pkg::F_CMP: begin
        if (hit) state_next = kts_pkg::F_PUSH;
        else     state_next = kts_pkg::F_READ;
      end
      kts_pkg::F_PUSH: begin
        if (!q_full) state_next = kts_pkg::F_IDLE;
      end
      default: state_next = kts_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    full   = (state != kts_pkg::F_IDLE);
    key_we = (state == kts_pkg::F_READ) && at_end && !tab_full;
    q_push = (state == kts_pkg::F_PUSH) && !q_full;
    q_item = cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= kts_pkg::F_IDLE;
      used         <= '0;
      drop_counter <= '0;
      scan_i       <= '0;
    end else begin
      state <= state_next;
      case (state)
        kts_pkg::F_IDLE: begin
          scan_i <= '0;
        end
        kts_pkg::F_READ: begin
          if (at_end) begin
            if (tab_full) drop_counter <= drop_counter + 64'd1;
            else          used <= used + kts_pkg::CNT_W'(1);
          end
        end
        kts_pkg::F_CMP: begin
          if (!hit) scan_i <= scan_i + kts_pkg::CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == kts_pkg::F_IDLE && push) begin
      smp      <= sample;
      cls.wall <= sample.wall_ns;
      cls.cpu  <= sample.cpu_ns;
    end
    if (state == kts_pkg::F_READ && at_end) begin
      cls.idx        <= used[kts_pkg::IDX_W-1:0];
      cls.fresh      <= !tab_full;
      cls.drop       <= tab_full;
      cls.drop_count <= tab_full ? drop_counter + 64'd1 : drop_counter;
    end
    if (state == kts_pkg::F_CMP && hit) begin
      cls.idx        <= scan_i[kts_pkg::IDX_W-1:0];
      cls.fresh      <= 1'b0;
      cls.drop       <= 1'b0;
      cls.drop_count <= drop_counter;
    end
  end

  `KTS_CHECK(a_used_bound, used <= kts_pkg::CNT_W'(kts_pkg::TABLE_DEPTH))
  `KTS_IMPLY(a_alloc_room, key_we, !tab_full && (scan_i == used))
  `KTS_NEXT(a_drop_step, drop_now, drop_counter == $past(drop_counter) + 64'd1)

endmodule

// ----- rtl/kts_queue.sv -----
// Two-entry queue of classified requests between lookup and update.
// Depends on kts_pkg.
module kts_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  kts_pkg::cls_t item_in,
  output logic          full,
  input  logic          pop,
  output kts_pkg::cls_t item_out,
  output logic          empty
);

  localparam int PTR_W = $clog2(kts_pkg::QDEPTH);
  localparam int CW    = $clog2(kts_pkg::QDEPTH + 1);

  kts_pkg::cls_t    slots [kts_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CW'(kts_pkg::QDEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign item_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(kts_pkg::QDEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(kts_pkg::QDEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (do_push && !do_pop)      count <= count + CW'(1);
      else if (do_pop && !do_push) count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= item_in;
  end

endmodule

// ----- rtl/kts_back.sv -----
// Update stage: read-modify-write of per-key statistics and result register.
// Depends on kts_pkg and kts_ram.
module kts_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  kts_pkg::cls_t    q_item,
  output logic             q_pop,
  output logic             empty,
  input  logic             pop,
  output kts_pkg::result_t result
);

  kts_pkg::b_state_t state, state_next;
  kts_pkg::cls_t     item;
  kts_pkg::result_t  res;
  kts_pkg::result_t  out_reg;
  logic              out_valid;
  logic              slot_free;

  logic              st_we;
  kts_pkg::stats_t   st_rdata;
  kts_pkg::stats_t   base;
  kts_pkg::stats_t   upd;
  logic [47:0]       wait_ns;

  assign slot_free = !out_valid || pop;

  kts_ram #(
    .WIDTH($bits(kts_pkg::stats_t)),
    .DEPTH(kts_pkg::TABLE_DEPTH)
  ) u_stats_ram (
    .clk  (clk),
    .we   (st_we),
    .waddr(item.idx),
    .wdata(upd),
    .raddr(q_item.idx),
    .rdata(st_rdata)
  );

  always_comb begin
    if (item.fresh) begin
      base          = '0;
      base.wall_min = '1;
    end else begin
      base = st_rdata;
    end
    wait_ns      = (item.wall >= item.cpu) ? item.wall - item.cpu : '0;
    upd.calls    = (base.calls == '1) ? base.calls : base.calls + 32'd1;
    upd.wall_sum = base.wall_sum + {16'd0, item.wall};
    upd.cpu_sum  = base.cpu_sum + {16'd0, item.cpu};
    upd.wait_sum = base.wait_sum + {16'd0, wait_ns};
    upd.wall_max = (item.wall > base.wall_max) ? item.wall : base.wall_max;
    upd.wall_min = (item.wall < base.wall_min) ? item.wall : base.wall_min;
  end

  always_comb begin
    state_next = state;
    case (state)
      kts_pkg::B_IDLE: begin
        if (!q_empty) state_next = q_item.drop ? kts_pkg::B_OUT : kts_pkg::B_CALC;
      end
      kts_pkg::B_CALC: state_next = kts_pkg::B_OUT;
      kts_pkg::B_OUT: begin
        if (slot_free) state_next = kts_pkg::B_IDLE;
      end
      default: state_next = kts_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop  = (state == kts_pkg::B_IDLE) && !q_empty;
    st_we  = (state == kts_pkg::B_CALC);
    empty  = !out_valid;
    result = out_reg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kts_pkg::B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == kts_pkg::B_OUT && slot_free) out_valid <= 1'b1;
      else if (pop)                             out_valid <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      item <= q_item;
      // a drop skips the table and reports zeros apart from its drop flag and count
      res.new_entry    <= 1'b0;
      res.dropped      <= q_item.drop;
      res.drop_count   <= q_item.drop_count;
      res.call_count   <= '0;
      res.wall_total   <= '0;
      res.cpu_total    <= '0;
      res.wait_total   <= '0;
      res.wall_maximum <= '0;
      res.wall_minimum <= '0;
    end
    if (state == kts_pkg::B_CALC) begin
      res.new_entry    <= item.fresh;
      res.dropped      <= 1'b0;
      res.drop_count   <= item.drop_count;
      res.call_count   <= upd.calls;
      res.wall_total   <= upd.wall_sum;
      res.cpu_total    <= upd.cpu_sum;
      res.wait_total   <= upd.wait_sum;
      res.wall_maximum <= upd.wall_max;
      res.wall_minimum <= upd.wall_min;
    end
    if (state == kts_pkg::B_OUT && slot_free) out_reg <= res;
  end

endmodule

// ----- rtl/keyed_timing_stats_table_top.sv -----
// Lookup compares the stored keys one by one over the single read port of the key
// RAM, then allocates a new key or, with the table full, drops the sample. Lookup
// takes a new sample only once the last is in the queue; the update runs in
// parallel behind a two-entry queue, and a drop skips its table update.
// Reset (synchronous): clears entry count, drop counter and all handshake state;
// table RAMs are not cleared and need no clearing pass.
module keyed_timing_stats_table_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  kts_pkg::sample_t sample,
  output logic             full,
  output logic             empty,
  input  logic             pop,
  output kts_pkg::result_t result
);

  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_empty;
  kts_pkg::cls_t q_in;
  kts_pkg::cls_t q_out;

  kts_front u_front (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .sample(sample),
    .full  (full),
    .q_push(q_push),
    .q_item(q_in),
    .q_full(q_full)
  );

  kts_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .item_in (q_in),
    .full    (q_full),
    .pop     (q_pop),
    .item_out(q_out),
    .empty   (q_empty)
  );

  kts_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_empty(q_empty),
    .q_item (q_out),
    .q_pop  (q_pop),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule

// ----- dv/keyed_timing_stats_table_checker.sv -----
// Checker for the keyed timing statistics table: watches both request channels,
// predicts each result from its own copy of the table and compares field by field.
// Depends on kts_pkg for the sample and result types.
module keyed_timing_stats_table_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic             full,
  input  kts_pkg::sample_t sample,
  input  logic             pop,
  input  logic             empty,
  input  kts_pkg::result_t result,
  output int               fails,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [47:0] WALL_ONES = '1;
  localparam logic [31:0] CALLS_SAT = '1;

  int unsigned       slot_of[logic [39:0]];
  kts_pkg::stats_t   entry_stats[kts_pkg::TABLE_DEPTH];
  int unsigned       slots_taken;
  logic [63:0]       drops_seen;
  kts_pkg::result_t  stats_due[$];

  initial begin
    fails = 0;
    pending = 0;
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    fails++;
  endtask

  // Work out the statistics that one sample leaves in its table entry.
  function automatic kts_pkg::result_t update_entry(input kts_pkg::sample_t s);
    logic [39:0] key;
    logic [47:0] idle;
    int unsigned slot;
    kts_pkg::result_t r;
    key = {s.type_id, s.device_id, s.metric_id};
    idle = (s.wall_ns < s.cpu_ns) ? '0 : s.wall_ns - s.cpu_ns;
    r = '0;
    if (slot_of.exists(key)) begin
      slot = slot_of[key];
    end else if (slots_taken >= kts_pkg::TABLE_DEPTH) begin
      drops_seen = drops_seen + 1;
      r.dropped = 1'b1;
      r.drop_count = drops_seen;
      return r;
    end else begin
      slot = slots_taken;
      slot_of[key] = slot;
      slots_taken++;
      entry_stats[slot] = '0;
      entry_stats[slot].wall_min = WALL_ONES;
      r.new_entry = 1'b1;
    end
    if (entry_stats[slot].calls != CALLS_SAT) entry_stats[slot].calls++;
    entry_stats[slot].wall_sum += 64'(s.wall_ns);
    entry_stats[slot].cpu_sum  += 64'(s.cpu_ns);
    entry_stats[slot].wait_sum += 64'(idle);
    if (s.wall_ns > entry_stats[slot].wall_max) entry_stats[slot].wall_max = s.wall_ns;
    if (s.wall_ns < entry_stats[slot].wall_min) entry_stats[slot].wall_min = s.wall_ns;
    r.drop_count   = drops_seen;
    r.call_count   = entry_stats[slot].calls;
    r.wall_total   = entry_stats[slot].wall_sum;
    r.cpu_total    = entry_stats[slot].cpu_sum;
    r.wait_total   = entry_stats[slot].wait_sum;
    r.wall_maximum = entry_stats[slot].wall_max;
    r.wall_minimum = entry_stats[slot].wall_min;
    return r;
  endfunction

  always @(posedge clk) begin
    kts_pkg::result_t want;
    if (rst) begin
      slot_of.delete();
      slots_taken = 0;
      drops_seen = '0;
      stats_due.delete();
    end else begin
      if (push && !full) stats_due.push_back(update_entry(sample));
      if (pop && !empty) begin
        if (stats_due.size() == 0) begin
          report("unexpected result", 64'd0, 64'd0);
        end else begin
          want = stats_due.pop_front();
          if (result.new_entry != want.new_entry)
            report("new_entry", result.new_entry, want.new_entry);
          if (result.dropped != want.dropped)
            report("dropped", result.dropped, want.dropped);
          if (result.drop_count != want.drop_count)
            report("drop_count", result.drop_count, want.drop_count);
          if (result.call_count != want.call_count)
            report("call_count", result.call_count, want.call_count);
          if (result.wall_total != want.wall_total)
            report("wall_total", result.wall_total, want.wall_total);
          if (result.cpu_total != want.cpu_total)
            report("cpu_total", result.cpu_total, want.cpu_total);
          if (result.wait_total != want.wait_total)
            report("wait_total", result.wait_total, want.wait_total);
          if (result.wall_maximum != want.wall_maximum)
            report("wall_maximum", result.wall_maximum, want.wall_maximum);
          if (result.wall_minimum != want.wall_minimum)
            report("wall_minimum", result.wall_minimum, want.wall_minimum);
        end
      end
    end
    pending <= stats_due.size();
  end

endmodule

// ----- dv/tb_keyed_timing_stats_table_top.sv -----
// Top of the keyed timing statistics table testbench: clock, reset, sample and
// pop stimulus, watchdog and verdict. Depends on kts_pkg, the table top and the checker.
module tb_keyed_timing_stats_table_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_SAMPLES = 830;
  localparam int KEY_POOL_MAX   = 160;
  localparam int IDLE_LIMIT     = 20000;
  localparam logic [47:0] WALL_MAX = '1;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             push = 1'b0;
  kts_pkg::sample_t sample = '0;
  logic             pop = 1'b0;
  logic             full, empty;
  kts_pkg::result_t result;
  int      fails, pending;
  int      idle_cycles = 0;
  logic [39:0] key_pool[$];

  always #5 clk = ~clk;

  keyed_timing_stats_table_top u_dut (
    .clk(clk), .rst(rst), .push(push), .sample(sample),
    .full(full), .empty(empty), .pop(pop), .result(result)
  );

  keyed_timing_stats_table_checker u_checker (
    .clk(clk), .rst(rst), .push(push), .full(full), .sample(sample),
    .pop(pop), .empty(empty), .result(result), .fails(fails), .pending(pending)
  );

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  function automatic logic [47:0] pick_duration();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return WALL_MAX;
      2: return 48'($urandom_range(0, 1000));
      3: return WALL_MAX - 48'($urandom_range(0, 1000));
      default: return 48'({$urandom, $urandom});
    endcase
  endfunction

  task automatic send_sample(input logic [39:0] key, input logic [47:0] wall,
                             input logic [47:0] cpu, input int gap);
    push <= 1'b1;
    sample <= {key, wall, cpu};
    do @(posedge clk); while (full);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Result side: mostly ready, with short and occasional long stalls.
  initial begin
    int stall;
    stall = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
        if ($urandom_range(0, 9) == 0) stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [39:0] key;
    logic [47:0] wall, cpu;
    int burst;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Extremes of ids and durations, fresh and repeated keys, clamped wait.
    send_sample('0, '0, '0, 0);
    send_sample('0, WALL_MAX, '0, 1);
    send_sample('0, '0, WALL_MAX, 0);
    send_sample('1, WALL_MAX, WALL_MAX, 2);
    send_sample('1, 48'd5, 48'd6, 0);
    send_sample('1, 48'd7, 48'd7, 0);
    send_sample({8'hff, 16'h0000, 16'hffff}, 48'd100, 48'd1, 3);
    send_sample({8'h00, 16'hffff, 16'h0000}, 48'd1, 48'd100, 0);
    send_sample({8'hff, 16'h0000, 16'hffff}, WALL_MAX, 48'd0, 0);
    send_sample({8'h00, 16'hffff, 16'h0000}, 48'd0, 48'd0, 0);
    send_sample({8'haa, 16'h5555, 16'haaaa}, 48'h555555555555, 48'haaaaaaaaaaaa, 0);
    send_sample({8'h55, 16'haaaa, 16'h5555}, 48'haaaaaaaaaaaa, 48'h555555555555, 1);
    push <= 1'b0;

    // Let the table drain completely before the random part.
    do @(posedge clk); while (pending != 0);

    burst = 0;
    for (int n = 0; n < RANDOM_SAMPLES; n++) begin
      if (key_pool.size() < 4 || (key_pool.size() < KEY_POOL_MAX && $urandom_range(0, 4) == 0)) begin
        key = 40'({$urandom, $urandom});
        key_pool.push_back(key);
      end else begin
        key = key_pool[$urandom_range(0, key_pool.size() - 1)];
      end
      wall = pick_duration();
      cpu = ($urandom_range(0, 2) == 0) ? wall : pick_duration();
      if (burst > 0) begin
        burst--;
        send_sample(key, wall, cpu, 0);
      end else begin
        if ($urandom_range(0, 29) == 0) burst = $urandom_range(5, 20);
        send_sample(key, wall, cpu, pick_gap());
      end
      if (n == RANDOM_SAMPLES / 2) begin
        push <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
    end
    push <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (50) @(posedge clk);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
